/* rtl/kmt_pkg.sv */
// Package for the killer move table: table geometry, slot and row types,
// request codes and the update bundle between the row logic and the top level.
// Depends on nothing; every other file in rtl but the checker uses it.
package kmt_pkg;

	// Table geometry.
	localparam int LEVELS = 64;
	localparam int SLOTS = 4;
	localparam int LEVEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Field widths.
	localparam int KEY_W = 32;
	localparam int HITS_W = 16;
	localparam int SLEVEL_W = 16;
	localparam int CNT_W = 9;

	localparam logic [HITS_W-1:0] HITS_MAX = '1;
	localparam logic [HITS_W-1:0] HITS_ONE = HITS_W'(1);

	// Request codes carried on func.
	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// One slot of a level.
	typedef struct packed {
		logic valid;
		logic [KEY_W-1:0] key;
		logic [HITS_W-1:0] hits;
	} slot_t;

	// One level row, stored as a single memory word.
	typedef slot_t [SLOTS-1:0] row_t;

	// Outcome of one request applied to one row.
	typedef struct packed {
		row_t row;
		logic wr;
		logic killer;
		logic grow;
	} upd_t;

endpackage

/* rtl/killer_move_table.sv */
// Killer move table top level. done is registered from busy and is high in the cycle
// after busy. No new request is taken while busy, during the read-modify-write of
// one level row in the row memory; busy is high for the cycle between read and
// write-back. Reset clears all control state and marks every row empty at once
// through per-row valid flops (no clearing pass). The receiver cannot stall:
// each result is shown for exactly one cycle.
module killer_move_table (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic func,
	input logic [kmt_pkg::SLEVEL_W-1:0] search_level,
	input logic [kmt_pkg::KEY_W-1:0] move_key,
	output logic done,
	output logic killer_found,
	output logic level_error,
	output logic [kmt_pkg::CNT_W-1:0] occupied_count
);

	logic accept;
	logic in_range;
	logic [kmt_pkg::LEVEL_W-1:0] idx;

	logic req_vld_s1;
	logic func_s1;
	logic err_s1;
	logic rowv_s1;
	logic [kmt_pkg::KEY_W-1:0] key_s1;
	logic [kmt_pkg::LEVEL_W-1:0] idx_s1;

	logic [kmt_pkg::LEVELS-1:0] row_vld_q;
	logic [kmt_pkg::CNT_W-1:0] cnt_q;
	logic [kmt_pkg::CNT_W-1:0] cnt_next;

	kmt_pkg::row_t rdata;
	kmt_pkg::row_t row_in;
	kmt_pkg::upd_t upd;
	logic wr_en;

	// Request decode.
	assign accept = start && !busy;
	assign in_range = (search_level < kmt_pkg::SLEVEL_W'(kmt_pkg::LEVELS));
	assign idx = search_level[kmt_pkg::LEVEL_W-1:0];
	assign busy = req_vld_s1;

	// Stage 1 control: one request in flight while its row is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else begin
			req_vld_s1 <= accept;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			err_s1 <= !in_range;
			key_s1 <= move_key;
			idx_s1 <= idx;
			rowv_s1 <= row_vld_q[idx];
		end
	end

	// Row memory.
	kmt_row_ram u_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(idx_s1),
		.wdata(upd.row),
		.re(accept),
		.raddr(idx),
		.rdata(rdata)
	);

	// A row never written reads as all slots empty.
	assign row_in = rowv_s1 ? rdata : '0;

	kmt_row_logic u_logic (
		.row(row_in),
		.func(func_s1),
		.key(key_s1),
		.upd(upd)
	);

	assign wr_en = req_vld_s1 && !err_s1 && upd.wr;
	assign cnt_next = cnt_q + kmt_pkg::CNT_W'(wr_en && upd.grow);

	// Per-row valid flags and the occupied slot count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			cnt_q <= '0;
		end else if (wr_en) begin
			row_vld_q[idx_s1] <= 1'b1;
			cnt_q <= cnt_next;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= req_vld_s1;
		end
	end

	// Result fields, captured as the row is written back.
	always_ff @(posedge clk) begin
		if (req_vld_s1) begin
			killer_found <= !err_s1 && upd.killer;
			level_error <= err_s1;
			occupied_count <= cnt_next;
		end
	end

endmodule

/* rtl/kmt_row_ram.sv */
// Row memory of the killer move table: one word per search level.
// One write port, one read port, read data registered.
// Depends on kmt_pkg.
module kmt_row_ram (
	input logic clk,
	input logic we,
	input logic [kmt_pkg::LEVEL_W-1:0] waddr,
	input kmt_pkg::row_t wdata,
	input logic re,
	input logic [kmt_pkg::LEVEL_W-1:0] raddr,
	output kmt_pkg::row_t rdata
);

	kmt_pkg::row_t mem [kmt_pkg::LEVELS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds between reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/kmt_row_logic.sv */
// Combinational update of one level row: hit search, fewest-hits victim pick,
// saturating hit count and the query scan that stops at the first hit or empty slot.
// Depends on kmt_pkg.
module kmt_row_logic (
	input kmt_pkg::row_t row,
	input logic func,
	input logic [kmt_pkg::KEY_W-1:0] key,
	output kmt_pkg::upd_t upd
);

	always_comb begin
		logic found;
		logic [kmt_pkg::SLOT_W-1:0] hit_idx;
		logic [kmt_pkg::SLOT_W-1:0] pick_idx;
		logic [kmt_pkg::HITS_W-1:0] pick_hits;
		logic stop;
		logic killer;

		found = 1'b0;
		hit_idx = '0;
		pick_idx = '0;
		pick_hits = row[0].hits;
		stop = 1'b0;
		killer = 1'b0;

		// First valid slot that holds the key.
		for (int i = 0; i < kmt_pkg::SLOTS; i++) begin
			if (!found && row[i].valid && row[i].key == key) begin
				found = 1'b1;
				hit_idx = kmt_pkg::SLOT_W'(i);
			end
		end

		// First slot with the fewest hits; empty slots carry zero hits.
		for (int i = 1; i < kmt_pkg::SLOTS; i++) begin
			if (row[i].hits < pick_hits) begin
				pick_hits = row[i].hits;
				pick_idx = kmt_pkg::SLOT_W'(i);
			end
		end

		// Query scan in slot order, ending at the first hit or the first empty slot.
		for (int i = 0; i < kmt_pkg::SLOTS; i++) begin
			if (!stop) begin
				if (!row[i].valid) begin
					stop = 1'b1;
				end else if (row[i].key == key) begin
					killer = 1'b1;
					stop = 1'b1;
				end
			end
		end

		// Build the row to write back for an add.
		upd.row = row;
		upd.wr = (func == kmt_pkg::FUNC_ADD);
		upd.killer = (func == kmt_pkg::FUNC_QUERY) && killer;
		upd.grow = 1'b0;
		if (func == kmt_pkg::FUNC_ADD) begin
			if (found) begin
				if (row[hit_idx].hits != kmt_pkg::HITS_MAX) begin
					upd.row[hit_idx].hits = row[hit_idx].hits + kmt_pkg::HITS_ONE;
				end
			end else begin
				upd.grow = !row[pick_idx].valid;
				upd.row[pick_idx].valid = 1'b1;
				upd.row[pick_idx].key = key;
				upd.row[pick_idx].hits = kmt_pkg::HITS_ONE;
			end
		end
	end

endmodule

/* rtl/kmt_checker.sv */
// Port-level checker for the killer move table, bound to the top level.
// Covers the busy window, the result strobe timing and error results.
// Depends on the top level's ports only.
module kmt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic killer_found,
	input logic level_error
);

	// A transfer in makes the block busy for exactly one cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a transfer in");

	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	// Every request gives its result the cycle after busy, and only then.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("result missing after busy");

	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request");

	// An ignored request never reports a killer.
	a_err_no_killer: assert property (@(posedge clk) disable iff (!arst_n)
		done && level_error |-> !killer_found)
		else $error("killer reported on a level error");

endmodule

bind killer_move_table kmt_checker u_kmt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.killer_found(killer_found),
	.level_error(level_error)
);

/* test/killer_move_table_tb.sv */
// Self-checking testbench for the killer move table: directed and random add and
// query requests, each checked against a predictor of the per-level slot store.
// Depends on kmt_pkg and the killer_move_table top level.
module killer_move_table_tb;
	import kmt_pkg::*;

	localparam int TABLE_ENTRIES = LEVELS * SLOTS;
	localparam int CYCLE_LIMIT = 50000;
	localparam int PRINT_LIMIT = 50;
	localparam int RANDOM_ITEMS = 300;
	localparam int QUIET_TAIL = 100;

	// One result as the block should report it.
	typedef struct packed {
		logic killer;
		logic lvl_err;
		logic [CNT_W-1:0] count;
	} kmt_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic func = FUNC_ADD;
	logic [SLEVEL_W-1:0] search_level = '0;
	logic [KEY_W-1:0] move_key = '0;
	logic done;
	logic killer_found;
	logic level_error;
	logic [CNT_W-1:0] occupied_count;

	// Predicted copy of the slot store.
	logic slot_used [TABLE_ENTRIES];
	logic [KEY_W-1:0] slot_tag [TABLE_ENTRIES];
	logic [HITS_W-1:0] slot_score [TABLE_ENTRIES];
	int unsigned used_slots;

	kmt_result_t pending_results[$];
	int mismatches = 0;
	int cycle_count = 0;

	killer_move_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.search_level(search_level),
		.move_key(move_key),
		.done(done),
		.killer_found(killer_found),
		.level_error(level_error),
		.occupied_count(occupied_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// Applies one request to the predicted store and returns the expected result.
	function automatic kmt_result_t apply_request(input logic f, input logic [SLEVEL_W-1:0] lvl,
			input logic [KEY_W-1:0] key);
		kmt_result_t r;
		int base;
		int a;
		int pick;
		logic found;
		logic stop;
		r = '0;
		found = 1'b0;
		stop = 1'b0;
		if (lvl >= LEVELS) begin
			r.lvl_err = 1'b1;
		end else begin
			base = int'(lvl) * SLOTS;
			pick = base;
			if (f == FUNC_ADD) begin
				// Reinforce a matching slot, else replace the first least-hit slot.
				for (int i = 0; i < SLOTS && !found; i++) begin
					a = base + i;
					if (slot_used[a] && slot_tag[a] == key) begin
						if (slot_score[a] != HITS_MAX)
							slot_score[a] = slot_score[a] + HITS_ONE;
						found = 1'b1;
					end else if (slot_score[a] < slot_score[pick]) begin
						pick = a;
					end
				end
				if (!found) begin
					if (!slot_used[pick])
						used_slots++;
					slot_used[pick] = 1'b1;
					slot_tag[pick] = key;
					slot_score[pick] = HITS_ONE;
				end
			end else begin
				// The scan ends at the first empty slot.
				for (int i = 0; i < SLOTS && !found && !stop; i++) begin
					a = base + i;
					if (!slot_used[a])
						stop = 1'b1;
					else if (slot_tag[a] == key)
						found = 1'b1;
				end
				r.killer = found;
			end
		end
		r.count = CNT_W'(used_slots);
		return r;
	endfunction

	// Offers one request from a rising edge and returns at the edge of its transfer.
	task automatic send_request(input logic f, input logic [SLEVEL_W-1:0] lvl,
			input logic [KEY_W-1:0] key);
		kmt_result_t exp_r;
		start <= 1'b1;
		func <= f;
		search_level <= lvl;
		move_key <= key;
		do @(negedge clk); while (busy);
		exp_r = apply_request(f, lvl, key);
		pending_results.insert(pending_results.size(), exp_r);
		@(posedge clk);
	endtask

	// Sender gap with noise on the request fields.
	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		func <= 1'($urandom);
		search_level <= SLEVEL_W'($urandom);
		move_key <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	// Holds off until every expected result has come back.
	task automatic wait_results_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Compares each result with the oldest expectation.
	always @(negedge clk) begin
		kmt_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				if (killer_found !== want.killer)
					report_mismatch($sformatf("killer_found %b, expected %b",
						killer_found, want.killer));
				if (level_error !== want.lvl_err)
					report_mismatch($sformatf("level_error %b, expected %b",
						level_error, want.lvl_err));
				if (occupied_count !== want.count)
					report_mismatch($sformatf("occupied_count %0d, expected %0d",
						occupied_count, want.count));
			end
		end
	end

	// Queries on empty levels, including key zero that matches no empty slot.
	task automatic test_empty_levels();
		send_request(FUNC_QUERY, '0, '0);
		send_request(FUNC_QUERY, SLEVEL_W'(LEVELS - 1), '1);
	endtask

	// Levels past the table are flagged and leave it unchanged.
	task automatic test_level_range();
		send_request(FUNC_ADD, SLEVEL_W'(LEVELS), 32'd1);
		send_request(FUNC_QUERY, SLEVEL_W'(LEVELS), 32'd1);
		send_request(FUNC_ADD, '1, '1);
		send_request(FUNC_QUERY, '1, '1);
		send_request(FUNC_QUERY, '0, 32'd1);
	endtask

	// Adds and queries at the extreme levels and keys.
	task automatic test_add_query();
		send_request(FUNC_ADD, '0, '0);
		send_request(FUNC_QUERY, '0, '0);
		send_request(FUNC_ADD, SLEVEL_W'(LEVELS - 1), '1);
		send_request(FUNC_QUERY, SLEVEL_W'(LEVELS - 1), '1);
		send_request(FUNC_QUERY, '0, '1);
	endtask

	// Least-hit replacement, ties going to the lowest slot.
	task automatic test_replacement();
		for (int s = 0; s < 4; s++)
			send_request(FUNC_ADD, 16'd1, 32'd10 + s);
		for (int s = 1; s < 4; s++)
			send_request(FUNC_ADD, 16'd1, 32'd10 + s);
		send_request(FUNC_ADD, 16'd1, 32'd14);
		send_request(FUNC_QUERY, 16'd1, 32'd10);
		send_request(FUNC_QUERY, 16'd1, 32'd14);
		send_request(FUNC_ADD, 16'd1, 32'd15);
		send_request(FUNC_QUERY, 16'd1, 32'd14);
		for (int s = 0; s < 5; s++)
			send_request(FUNC_ADD, 16'd2, 32'd20 + s);
		send_request(FUNC_QUERY, 16'd2, 32'd20);
	endtask

	// A slot reinforced many times survives replacement of its weaker neighbors.
	task automatic test_hit_count();
		for (int n = 0; n < 12; n++)
			send_request(FUNC_ADD, 16'd5, 32'hCAFE_0001);
		for (int s = 2; s < 5; s++)
			send_request(FUNC_ADD, 16'd5, 32'hCAFE_0000 + s);
		send_request(FUNC_ADD, 16'd5, 32'hCAFE_0005);
		send_request(FUNC_QUERY, 16'd5, 32'hCAFE_0001);
		send_request(FUNC_QUERY, 16'd5, 32'hCAFE_0002);
		send_request(FUNC_QUERY, 16'd5, 32'hCAFE_0005);
	endtask

	// Random traffic on a few busy levels with a small key pool, plus noise.
	task automatic test_random_traffic(input int items);
		logic f;
		logic [SLEVEL_W-1:0] lvl;
		logic [KEY_W-1:0] key;
		int pick;
		for (int i = 0; i < items; i++) begin
			f = 1'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				lvl = SLEVEL_W'($urandom_range(0, 7));
			else if (pick < 92)
				lvl = SLEVEL_W'($urandom_range(0, LEVELS - 1));
			else
				lvl = SLEVEL_W'($urandom_range(LEVELS, 16'hFFFF));
			if ($urandom_range(0, 9) < 8)
				key = KEY_W'($urandom_range(0, 5));
			else
				key = $urandom;
			send_request(f, lvl, key);
			// Idle bursts come in stretches and stop for the tail of the run.
			if (i < items - QUIET_TAIL && (i / 40) % 3 != 2 && $urandom_range(0, 2) == 0)
				pause_sender($urandom_range(1, 14));
		end
	endtask

	// Fills every slot so the occupied count reaches its maximum.
	task automatic test_fill_table();
		for (int l = 0; l < LEVELS; l++)
			for (int s = 0; s < SLOTS; s++)
				send_request(FUNC_ADD, SLEVEL_W'(l), 32'h8000_0000 | (l << 8) | s);
		send_request(FUNC_QUERY, SLEVEL_W'(LEVELS - 1), 32'h8000_0000 | ((LEVELS - 1) << 8));
		send_request(FUNC_ADD, '0, 32'h7FFF_FFFF);
		send_request(FUNC_ADD, '1, '0);
	endtask

	initial begin
		for (int a = 0; a < TABLE_ENTRIES; a++) begin
			slot_used[a] = 1'b0;
			slot_tag[a] = '0;
			slot_score[a] = '0;
		end
		used_slots = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_levels();
		test_level_range();
		test_add_query();
		test_replacement();
		wait_results_drained();
		test_hit_count();
		wait_results_drained();
		test_random_traffic(RANDOM_ITEMS);
		test_fill_table();
		wait_results_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/kmt_pkg.sv
rtl/kmt_row_ram.sv
rtl/kmt_row_logic.sv
rtl/killer_move_table.sv
rtl/kmt_checker.sv
test/killer_move_table_tb.sv
